// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/swm_pkg.sv =====
// Package with payload types and constants of the sliding window median filter.
package swm_pkg;
  localparam int unsigned FieldBits = 32;
  localparam int unsigned NumFields = 6;

  typedef struct packed {
    logic signed [FieldBits-1:0] trans_x;
    logic signed [FieldBits-1:0] trans_y;
    logic signed [FieldBits-1:0] trans_z;
    logic signed [FieldBits-1:0] rot_x;
    logic signed [FieldBits-1:0] rot_y;
    logic signed [FieldBits-1:0] rot_z;
  } swm_in_t;

  typedef struct packed {
    logic signed [FieldBits-1:0] med_trans_x;
    logic signed [FieldBits-1:0] med_trans_y;
    logic signed [FieldBits-1:0] med_trans_z;
    logic signed [FieldBits-1:0] med_rot_x;
    logic signed [FieldBits-1:0] med_rot_y;
    logic signed [FieldBits-1:0] med_rot_z;
  } swm_out_t;

  typedef enum logic [1:0] {
    StIdle,
    StCount,
    StOut
  } swm_state_e;

  // Control bundle from the sequencer to every lane.
  typedef struct packed {
    logic write;
    logic clear;
    logic step;
  } swm_lane_ctl_t;
endpackage

// ===== hdl/swm_lane.sv =====
// One lane: sample ring and rank counting over one stored sample per cycle.
module swm_lane import swm_pkg::*; #(
  parameter int unsigned Held = 14,
  parameter int unsigned SampleBits = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  swm_lane_ctl_t                ctl_i,
  input  logic [$clog2(Held)-1:0]      wr_slot_i,
  input  logic [$clog2(Held)-1:0]      rd_slot_i,
  input  logic [$clog2(Held)-1:0]      cand_slot_i,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic signed [SampleBits-1:0] med_o
);
  localparam int unsigned CntBits = $clog2(Held + 1);
  localparam int unsigned LoRank = (Held - 1) / 2;
  localparam int unsigned HiRank = Held / 2;

  logic signed [SampleBits-1:0] mem [Held];
  logic signed [SampleBits-1:0] cand_q, other_q;
  logic signed [SampleBits-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CntBits-1:0] less_q, less_d, leq_q, leq_d;
  logic other_ok_q;
  logic signed [SampleBits:0] sum;

  always_ff @(posedge clk_i) begin
    if (ctl_i.write) begin
      mem[wr_slot_i] <= sample_i;
    end
    cand_q <= mem[cand_slot_i];
    other_q <= mem[rd_slot_i];
  end

  // Candidate c has rank range [less, leq); it is the k-th if less <= k < leq.
  always_comb begin
    less_d = less_q;
    leq_d = leq_q;
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctl_i.clear) begin
      less_d = '0;
      leq_d = '0;
    end else if (other_ok_q) begin
      if (other_q < cand_q) begin
        less_d = less_q + CntBits'(1);
      end
      if (other_q <= cand_q) begin
        leq_d = leq_q + CntBits'(1);
      end
    end
    if (ctl_i.step) begin
      if (less_d <= CntBits'(LoRank) && leq_d > CntBits'(LoRank)) begin
        lo_d = cand_q;
      end
      if (less_d <= CntBits'(HiRank) && leq_d > CntBits'(HiRank)) begin
        hi_d = cand_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      less_q <= '0;
      leq_q <= '0;
      other_ok_q <= 1'b0;
    end else begin
      less_q <= less_d;
      leq_q <= leq_d;
      other_ok_q <= !ctl_i.clear && !ctl_i.write;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign sum = {lo_q[SampleBits-1], lo_q} + {hi_q[SampleBits-1], hi_q};
  assign med_o = sum[SampleBits:1];
endmodule

// ===== hdl/sliding_window_median_top.sv =====
// Top level of the sliding window median filter: sequencer, lanes and merge.
// Usage:
//   in_valid_i/in_ready_o/in_data_i carry one beat of six Q16.16 samples.
//   out_valid_o/out_ready_i/out_data_o carry one beat of six medians.
//   Each lane keeps the last WINDOW-1 samples in a small memory. The first
//   WINDOW-1 beats only fill the window and give no result. Every beat after
//   that replaces the oldest sample and yields one result beat.
//   The median is found by rank counting: for each of the WINDOW-1 held
//   samples the lane scans all held samples, one memory read per cycle.
//   The result beat is registered once the scan of the last candidate is
//   done, and no new beat is taken while the scan runs. A filling beat is
//   only written to the lane memories and leaves the block idle.
//   A new beat is accepted once the previous result beat has left the output
//   register; while the receiver stalls, that register holds the result and
//   the block waits. Reset empties the window and drops any pending result.
module sliding_window_median_top import swm_pkg::*; #(
  parameter int unsigned WINDOW = 15
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  swm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output swm_out_t out_data_o
);
  localparam int unsigned Held = WINDOW - 1;
  localparam int unsigned SlotBits = $clog2(Held);
  localparam int unsigned CntBits = $clog2(Held + 1);

  swm_state_e state_q, state_d;
  logic [CntBits-1:0] fill_q, fill_d;
  logic [SlotBits-1:0] oldest_q, oldest_d, cand_q, cand_d, scan_q, scan_d;
  logic [CntBits-1:0] phase_q, phase_d;
  logic out_valid_q;
  swm_out_t out_q;
  swm_lane_ctl_t ctl;
  logic [SlotBits-1:0] wr_slot;
  logic accept;
  logic signed [FieldBits-1:0] field_in [NumFields];
  logic signed [FieldBits-1:0] field_out [NumFields];
  logic last_scan, last_cand;

  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign accept = in_valid_i && in_ready_o;
  assign wr_slot = (fill_q < CntBits'(Held)) ? SlotBits'(fill_q) : oldest_q;
  assign last_scan = (scan_q == SlotBits'(Held - 1));
  assign last_cand = (cand_q == SlotBits'(Held - 1));

  assign field_in[0] = in_data_i.trans_x;
  assign field_in[1] = in_data_i.trans_y;
  assign field_in[2] = in_data_i.trans_z;
  assign field_in[3] = in_data_i.rot_x;
  assign field_in[4] = in_data_i.rot_y;
  assign field_in[5] = in_data_i.rot_z;

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    oldest_d = oldest_q;
    cand_d = cand_q;
    scan_d = scan_q;
    phase_d = phase_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (fill_q < CntBits'(Held)) begin
            fill_d = fill_q + CntBits'(1);
          end else begin
            oldest_d = (oldest_q == SlotBits'(Held - 1)) ? '0 : oldest_q + SlotBits'(1);
            state_d = StCount;
            cand_d = '0;
            scan_d = '0;
            phase_d = '0;
          end
        end
      end
      StCount: begin
        // phase 0: clear and prime; phase 1: Held reads; phase 2: settle and step.
        if (phase_q == '0) begin
          phase_d = CntBits'(1);
          scan_d = '0;
        end else if (phase_q == CntBits'(1)) begin
          if (last_scan) begin
            phase_d = CntBits'(2);
          end else begin
            scan_d = scan_q + SlotBits'(1);
          end
        end else begin
          phase_d = '0;
          scan_d = '0;
          if (last_cand) begin
            state_d = StOut;
          end else begin
            cand_d = cand_q + SlotBits'(1);
          end
        end
      end
      StOut: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_q)
      StIdle: ctl.write = accept;
      StCount: begin
        ctl.clear = (phase_q == '0);
        ctl.step = (phase_q == CntBits'(2));
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q <= '0;
      oldest_q <= '0;
      cand_q <= '0;
      scan_q <= '0;
      phase_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      oldest_q <= oldest_d;
      cand_q <= cand_d;
      scan_q <= scan_d;
      phase_q <= phase_d;
      if (state_q == StOut) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  for (genvar l = 0; l < NumFields; l++) begin : g_lane
    swm_lane #(
      .Held(Held),
      .SampleBits(FieldBits)
    ) u_lane (
      .clk_i(clk_i),
      .rst_ni(rst_ni),
      .ctl_i(ctl),
      .wr_slot_i(wr_slot),
      .rd_slot_i(scan_q),
      .cand_slot_i(cand_q),
      .sample_i(field_in[l]),
      .med_o(field_out[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StOut) begin
      out_q.med_trans_x <= field_out[0];
      out_q.med_trans_y <= field_out[1];
      out_q.med_trans_z <= field_out[2];
      out_q.med_rot_x <= field_out[3];
      out_q.med_rot_y <= field_out[4];
      out_q.med_rot_z <= field_out[5];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
endmodule

// ===== hdl/swm_checker.sv =====
// Port checker for the sliding window median filter, bound to the top level.
`include "assert_macros.svh"
module swm_checker import swm_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input swm_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input swm_out_t out_data_o
);
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o))
  `ASSERT_IMPL(a_no_in_while_out, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_o && out_valid_o,
    1'b0)
  `ASSERT_NEXT(a_ready_after_out, clk_i, rst_ni, out_valid_o && out_ready_i,
    in_ready_o || out_valid_o == 1'b0)
endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o),
  .in_data_i(in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o(out_data_o)
);
